>>> src/efod_pkg.sv
// Shared types and constants for the envelope follower with onset detection.
`timescale 1ns / 1ps
`default_nettype none

package efod_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ATTACK       = 3'd0,
    REG_RELEASE      = 3'd1,
    REG_ONS_ATTACK   = 3'd2,
    REG_ONS_RELEASE  = 3'd3,
    REG_REL_THRESH   = 3'd4,
    REG_ABS_FLOOR    = 3'd5,
    REG_PEAK_DECAY   = 3'd6
  } reg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COEF_REG_W = 25;
  localparam int unsigned MAG_W      = 32;

  // Reset values of the configuration registers.
  localparam logic [COEF_REG_W-1:0] RST_ATTACK      = 25'd189147;
  localparam logic [COEF_REG_W-1:0] RST_RELEASE     = 25'd2536;
  localparam logic [COEF_REG_W-1:0] RST_ONS_ATTACK  = 25'd189147;
  localparam logic [COEF_REG_W-1:0] RST_ONS_RELEASE = 25'd38000;
  localparam logic [COEF_REG_W-1:0] RST_REL_THRESH  = 25'd5872026;
  localparam logic [MAG_W-1:0]      RST_ABS_FLOOR   = 32'd42949673;
  localparam logic [COEF_REG_W-1:0] RST_PEAK_DECAY  = 25'd16777048;

  // Lowest value of the slow peak, about 1e-4 in Q1.31.
  localparam logic [MAG_W-1:0]      PEAK_FLOOR      = 32'd214748;

  // Which operand pair is loaded into the shared multiplier.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MAIN = 3'd1,
    OP_ONS  = 3'd2,
    OP_PEAK = 3'd3,
    OP_THR  = 3'd4
  } op_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAIN_OP,
    ST_MAIN_MUL,
    ST_ONS_MUL,
    ST_PEAK_MUL,
    ST_PEAK_UPD,
    ST_THR_OP,
    ST_THR_MUL,
    ST_THR_UPD
  } state_e;

  typedef struct packed {
    logic    mag_ld;
    op_sel_e op_sel;
    logic    mul_en;
    logic    main_upd;
    logic    ons_upd;
    logic    peak_upd;
    logic    res_ld;
  } efod_cmd_t;

endpackage

`default_nettype wire

>>> src/efod_ctrl.sv
// Sequencer that steps each sample through the shared multiplier and drives both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module efod_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output efod_pkg::efod_cmd_t      cmd_o
);

  efod_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efod_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The multiplier is shared in a short overlapped schedule: while one product
  // is formed, the next operand pair is loaded and the previous result is applied.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      efod_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.mag_ld = 1'b1;
          state_d      = efod_pkg::ST_MAIN_OP;
        end
      end
      efod_pkg::ST_MAIN_OP: begin
        cmd_o.op_sel = efod_pkg::OP_MAIN;
        state_d      = efod_pkg::ST_MAIN_MUL;
      end
      efod_pkg::ST_MAIN_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op_sel = efod_pkg::OP_ONS;
        state_d      = efod_pkg::ST_ONS_MUL;
      end
      efod_pkg::ST_ONS_MUL: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.main_upd = 1'b1;
        cmd_o.op_sel   = efod_pkg::OP_PEAK;
        state_d        = efod_pkg::ST_PEAK_MUL;
      end
      efod_pkg::ST_PEAK_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.ons_upd = 1'b1;
        state_d       = efod_pkg::ST_PEAK_UPD;
      end
      efod_pkg::ST_PEAK_UPD: begin
        cmd_o.peak_upd = 1'b1;
        state_d        = efod_pkg::ST_THR_OP;
      end
      efod_pkg::ST_THR_OP: begin
        cmd_o.op_sel = efod_pkg::OP_THR;
        state_d      = efod_pkg::ST_THR_MUL;
      end
      efod_pkg::ST_THR_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = efod_pkg::ST_THR_UPD;
      end
      efod_pkg::ST_THR_UPD: begin
        // The result register is free when empty or when its beat leaves now.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = efod_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = efod_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != efod_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> src/efod_datapath.sv
// Configuration registers, follower state, shared multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none

module efod_datapath #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire efod_pkg::efod_cmd_t                 cmd_i,
  input  wire logic [SAMPLE_BITS-1:0]              sample_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [efod_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [efod_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [efod_pkg::MAG_W-1:0]               envelope_o,
  output logic                                     playing_o,
  output logic                                     onset_o
);

  localparam int unsigned MW        = efod_pkg::MAG_W;
  localparam int unsigned COEF_W    = COEF_FRAC_BITS + 1;
  localparam int unsigned PW        = MW + COEF_W;
  localparam int unsigned MAG_SHIFT = MW - SAMPLE_BITS;
  localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0]     HALF     = {{(PW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  // Coefficients above one are held as one, so the stored value is already saturated.
  function automatic logic [COEF_W-1:0] sat_coef(input logic [efod_pkg::COEF_REG_W-1:0] v);
    logic [31:0] ext;
    logic [31:0] one;
    ext = 32'(v);
    one = 32'(COEF_ONE);
    if (ext > one) begin
      sat_coef = COEF_ONE;
    end else begin
      sat_coef = COEF_W'(v);
    end
  endfunction

  // Configuration registers.
  logic [COEF_W-1:0] att_q, rel_q, ons_att_q, ons_rel_q, rel_thr_q, decay_q;
  logic [MW-1:0]     floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q     <= sat_coef(efod_pkg::RST_ATTACK);
      rel_q     <= sat_coef(efod_pkg::RST_RELEASE);
      ons_att_q <= sat_coef(efod_pkg::RST_ONS_ATTACK);
      ons_rel_q <= sat_coef(efod_pkg::RST_ONS_RELEASE);
      rel_thr_q <= sat_coef(efod_pkg::RST_REL_THRESH);
      floor_q   <= efod_pkg::RST_ABS_FLOOR;
      decay_q   <= sat_coef(efod_pkg::RST_PEAK_DECAY);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        efod_pkg::REG_ATTACK:      att_q     <= sat_coef(cfg_data_i[efod_pkg::COEF_REG_W-1:0]);
        efod_pkg::REG_RELEASE:     rel_q     <= sat_coef(cfg_data_i[efod_pkg::COEF_REG_W-1:0]);
        efod_pkg::REG_ONS_ATTACK:  ons_att_q <= sat_coef(cfg_data_i[efod_pkg::COEF_REG_W-1:0]);
        efod_pkg::REG_ONS_RELEASE: ons_rel_q <= sat_coef(cfg_data_i[efod_pkg::COEF_REG_W-1:0]);
        efod_pkg::REG_REL_THRESH:  rel_thr_q <= sat_coef(cfg_data_i[efod_pkg::COEF_REG_W-1:0]);
        efod_pkg::REG_ABS_FLOOR:   floor_q   <= cfg_data_i[MW-1:0];
        efod_pkg::REG_PEAK_DECAY:  decay_q   <= sat_coef(cfg_data_i[efod_pkg::COEF_REG_W-1:0]);
        default: ;
      endcase
    end
  end

  // Rectifier. Taken as unsigned, the negation of the most negative code is the
  // code itself, which is exactly a magnitude of one.
  logic [SAMPLE_BITS-1:0] abs_val;
  logic [MW-1:0]          mag_d, mag_q;

  always_comb begin
    if (sample_i[SAMPLE_BITS-1]) begin
      abs_val = ~sample_i + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
    end else begin
      abs_val = sample_i;
    end
    mag_d = MW'(abs_val) << MAG_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mag_ld) begin
      mag_q <= mag_d;
    end
  end

  // Follower state.
  logic [MW-1:0] main_q, main_d, ons_q, ons_d, peak_q, peak_d;
  logic          main_up_q, ons_up_q, prev_play_q;

  // Operand registers and the product register of the shared multiplier.
  logic [MW-1:0]     a_q, a_d;
  logic [COEF_W-1:0] b_q, b_d;
  logic [PW-1:0]     p_q;
  logic [MW-1:0]     scaled;
  logic              main_up, ons_up, op_ld;

  assign main_up = mag_q > main_q;
  assign ons_up  = mag_q > ons_q;

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    op_ld = 1'b1;
    unique case (cmd_i.op_sel)
      efod_pkg::OP_MAIN: begin
        a_d = main_up ? (mag_q - main_q) : (main_q - mag_q);
        b_d = main_up ? att_q : rel_q;
      end
      efod_pkg::OP_ONS: begin
        a_d = ons_up ? (mag_q - ons_q) : (ons_q - mag_q);
        b_d = ons_up ? ons_att_q : ons_rel_q;
      end
      efod_pkg::OP_PEAK: begin
        a_d = peak_q;
        b_d = decay_q;
      end
      efod_pkg::OP_THR: begin
        a_d = peak_q;
        b_d = rel_thr_q;
      end
      default: begin
        op_ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op_ld) begin
      a_q <= a_d;
      b_q <= b_d;
    end
    if (cmd_i.mul_en) begin
      // Rounding to nearest is folded into the product as an accumulate term.
      p_q <= PW'(a_q) * PW'(b_q) + HALF;
    end
  end

  assign scaled = p_q[COEF_FRAC_BITS +: MW];

  // Peak: jump up to the onset envelope, else decay, and never below the floor.
  logic [MW-1:0] peak_cand;
  assign peak_cand = (ons_q > peak_q) ? ons_q : scaled;

  always_comb begin
    main_d = main_up_q ? (main_q + scaled) : (main_q - scaled);
    ons_d  = ons_up_q ? (ons_q + scaled) : (ons_q - scaled);
    peak_d = (peak_cand < efod_pkg::PEAK_FLOOR) ? efod_pkg::PEAK_FLOOR : peak_cand;
  end

  // The threshold is the larger of the scaled peak and the floor.
  logic playing;
  assign playing = (ons_q > scaled) && (ons_q > floor_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q      <= '0;
      ons_q       <= '0;
      peak_q      <= '0;
      prev_play_q <= 1'b0;
      main_up_q   <= 1'b0;
      ons_up_q    <= 1'b0;
    end else begin
      if (cmd_i.op_sel == efod_pkg::OP_MAIN) begin
        main_up_q <= main_up;
      end
      if (cmd_i.op_sel == efod_pkg::OP_ONS) begin
        ons_up_q <= ons_up;
      end
      if (cmd_i.main_upd) begin
        main_q <= main_d;
      end
      if (cmd_i.ons_upd) begin
        ons_q <= ons_d;
      end
      if (cmd_i.peak_upd) begin
        peak_q <= peak_d;
      end
      if (cmd_i.res_ld) begin
        prev_play_q <= playing;
      end
    end
  end

  // Result register, held while the output beat is stalled.
  logic [MW-1:0] env_out_q;
  logic          play_out_q, onset_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      env_out_q   <= main_q;
      play_out_q  <= playing;
      onset_out_q <= playing & ~prev_play_q;
    end
  end

  assign envelope_o = env_out_q;
  assign playing_o  = play_out_q;
  assign onset_o    = onset_out_q;

endmodule

`default_nettype wire

>>> src/envelope_follower_onset_detector.sv
// Top level of the attack/release envelope follower with onset detection.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o   sample_i
//   out      output     out_valid_o / out_stall_i envelope_o, playing_o, onset_o
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One sample passes through the accept cycle plus eight steps that share a
// single multiplier (main follower, onset follower, peak decay, threshold).
// The next sample is accepted once the result is in the output register, so
// samples never overlap, and a stalled output also holds off the next sample.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the envelopes, the peak and the playing history.
// A stalled output beat holds the last step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module envelope_follower_onset_detector #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned COEF_FRAC_BITS = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]          sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [efod_pkg::MAG_W-1:0]           envelope_o,
  output logic                                 playing_o,
  output logic                                 onset_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [efod_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [efod_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  efod_pkg::efod_cmd_t cmd;

  efod_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  efod_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sample_i    (sample_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .envelope_o  (envelope_o),
    .playing_o   (playing_o),
    .onset_o     (onset_o)
  );

endmodule

`default_nettype wire

>>> src/efod_checker.sv
// Port-level checks for the envelope follower, attached to the top level by bind.
`timescale 1ns / 1ps
`default_nettype none

module efod_checker #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic [SAMPLE_BITS-1:0] sample_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [31:0]            envelope_o,
  input wire logic                   playing_o,
  input wire logic                   onset_o
);

  // A stalled input beat keeps its valid and its sample.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(sample_i))
    else $error("stalled input beat changed");

  // A stalled result beat keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(envelope_o)
      && $stable(playing_o) && $stable(onset_o))
    else $error("stalled result beat changed");

  // An onset can only be flagged on a sample that is playing.
  a_onset_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && onset_o |-> playing_o)
    else $error("onset without playing");

  // One sample is worked on at a time, so an accepted beat closes the input.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a sample is in progress");

  // The followers never overshoot, so the envelope stays at or below one.
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> envelope_o <= 32'h8000_0000)
    else $error("envelope above full scale");

endmodule

bind envelope_follower_onset_detector efod_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_efod_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .sample_i    (sample_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .envelope_o  (envelope_o),
  .playing_o   (playing_o),
  .onset_o     (onset_o)
);

`default_nettype wire
